>>> hdl/tccw_pkg.sv
package tccw_pkg;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_BODY,
        ST_SCROLL,
        ST_FILL,
        ST_CLEAR,
        ST_RD_DATA,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        MODE_PUT    = 2'd0,
        MODE_READ   = 2'd1,
        MODE_CURSOR = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] RESET_FILL_ATTR = 8'h07;

    localparam int OUT_COL_W = 7;
    localparam int OUT_ROW_W = 5;
    localparam int OUT_LIN_W = 11;

endpackage

>>> hdl/text_console_cell_writer_unit.sv
// Text console cell writer: a COLUMNS x ROWS character console held in two
// synchronous stores with a write and a read port (char and attr byte per cell).
// Input channel: i_valid / o_stall with i_mode, i_char_code, i_col, i_row.
// Result channel: o_valid / i_stall, one result word per input word, giving the
// cursor, the addressed cell (read mode only) and the scroll count.
// Config channel: i_cfg_valid / o_cfg_ready (always ready) writes fill_attr.
// Clear and scroll sweep the stores one cell per cycle through the single write
// port, with the scroll copy reading one cell ahead.
// One word is in work at a time; the next is taken as soon as the result is
// in the output register, even if that result is still waiting.
// After reset a clearing pass writes a space with attribute 7 to every cell;
// o_stall stays high during it, config is taken.
// When the receiver stalls, the result holds in the output register and a
// following word that finishes stays in its last step until the register frees.
module text_console_cell_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_char_code,
    input  logic [6:0]  i_col,
    input  logic [4:0]  i_row,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic [10:0] o_cursor_linear,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_attr,
    output logic [31:0] o_scroll_count,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int IW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int LW    = $clog2(CELLS + 1);

    localparam logic [IW-1:0] IDX_LAST      = IW'(CELLS - 1);
    localparam logic [IW-1:0] IDX_ROW1      = IW'(COLUMNS);
    localparam logic [IW-1:0] IDX_LAST_ROW  = IW'(CELLS - COLUMNS);
    localparam logic [CW-1:0] WRAP_COL      = CW'(COLUMNS);
    localparam logic [CW-1:0] MAX_COL       = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW      = RW'(ROWS - 1);

    // cell stores
    logic [7:0] r_char_mem [CELLS];
    logic [7:0] r_attr_mem [CELLS];
    logic [7:0] r_rd_char;
    logic [7:0] r_rd_attr;

    tccw_pkg::t_state r_state, n_state;
    logic [7:0]    r_ch, n_ch;
    logic [CW-1:0] r_cur_col, n_cur_col;
    logic [RW-1:0] r_cur_row, n_cur_row;
    logic [31:0]   r_scrolls, n_scrolls;
    logic [7:0]    r_fill_attr;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_cp_valid, n_cp_valid;
    logic [IW-1:0] r_cp_addr, n_cp_addr;
    logic          r_scroll_to_body, n_scroll_to_body;
    logic [1:0]    r_tab_cnt, n_tab_cnt;
    logic          r_rd_ok, n_rd_ok;
    logic [7:0]    r_res_char, n_res_char;
    logic [7:0]    r_res_attr, n_res_attr;

    logic          r_out_valid, n_out_valid;
    logic [6:0]    r_out_col, n_out_col;
    logic [4:0]    r_out_row, n_out_row;
    logic [10:0]   r_out_lin, n_out_lin;
    logic [7:0]    r_out_char, n_out_char;
    logic [7:0]    r_out_attr, n_out_attr;
    logic [31:0]   r_out_scrolls, n_out_scrolls;

    // store access
    logic          w_we_char;
    logic          w_we_attr;
    logic [IW-1:0] w_waddr;
    logic [7:0]    w_wchar;
    logic [7:0]    w_wattr;
    logic [IW-1:0] w_raddr;

    // cursor after a pending wrap, and the backspace target
    logic [CW-1:0] w_wr_col;
    logic [RW-1:0] w_wr_row;
    logic [CW-1:0] w_bs_col;
    logic [RW-1:0] w_bs_row;
    logic [IW-1:0] w_put_addr;
    logic [IW-1:0] w_bs_addr;
    logic [LW-1:0] w_lin;
    logic          w_in_ok;

    assign o_stall         = (r_state != tccw_pkg::ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_cursor_col    = r_out_col;
    assign o_cursor_row    = r_out_row;
    assign o_cursor_linear = r_out_lin;
    assign o_cell_char     = r_out_char;
    assign o_cell_attr     = r_out_attr;
    assign o_scroll_count  = r_out_scrolls;
    assign o_cfg_ready     = 1'b1;

    always_comb begin
        w_wr_col = (r_cur_col == WRAP_COL) ? '0 : r_cur_col;
        w_wr_row = ((r_cur_col == WRAP_COL) && (r_cur_row != LAST_ROW))
                   ? r_cur_row + 1'b1 : r_cur_row;
        w_bs_col = (w_wr_col == '0) ? MAX_COL : w_wr_col - 1'b1;
        w_bs_row = (w_wr_col == '0) ? w_wr_row - 1'b1 : w_wr_row;
        w_put_addr = IW'(IW'(w_wr_row) * IW'(COLUMNS) + IW'(w_wr_col));
        w_bs_addr  = IW'(IW'(w_bs_row) * IW'(COLUMNS) + IW'(w_bs_col));
        w_lin      = LW'(LW'(r_cur_row) * LW'(COLUMNS) + LW'(r_cur_col));
        w_in_ok    = (32'(i_col) < COLUMNS) && (32'(i_row) < ROWS);
    end

    always_comb begin
        n_state          = r_state;
        n_ch             = r_ch;
        n_cur_col        = r_cur_col;
        n_cur_row        = r_cur_row;
        n_scrolls        = r_scrolls;
        n_idx            = r_idx;
        n_cp_valid       = r_cp_valid;
        n_cp_addr        = r_cp_addr;
        n_scroll_to_body = r_scroll_to_body;
        n_tab_cnt        = r_tab_cnt;
        n_rd_ok          = r_rd_ok;
        n_res_char       = r_res_char;
        n_res_attr       = r_res_attr;
        n_out_valid      = r_out_valid && i_stall;
        n_out_col        = r_out_col;
        n_out_row        = r_out_row;
        n_out_lin        = r_out_lin;
        n_out_char       = r_out_char;
        n_out_attr       = r_out_attr;
        n_out_scrolls    = r_out_scrolls;

        w_we_char = 1'b0;
        w_we_attr = 1'b0;
        w_waddr   = r_idx;
        w_wchar   = tccw_pkg::CH_SPACE;
        w_wattr   = r_fill_attr;
        w_raddr   = r_idx;

        case (r_state)
            tccw_pkg::ST_INIT: begin
                w_we_char = 1'b1;
                w_we_attr = 1'b1;
                w_wattr   = tccw_pkg::RESET_FILL_ATTR;
                if (r_idx == IDX_LAST) begin
                    n_state = tccw_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            tccw_pkg::ST_IDLE: begin
                w_raddr = w_in_ok ? IW'(32'(i_row) * COLUMNS + 32'(i_col)) : '0;
                if (i_valid) begin
                    n_ch       = i_char_code;
                    n_res_char = '0;
                    n_res_attr = '0;
                    n_tab_cnt  = '0;
                    n_rd_ok    = w_in_ok;
                    case (tccw_pkg::t_mode'(i_mode))
                        tccw_pkg::MODE_PUT: begin
                            n_state = tccw_pkg::ST_CHECK;
                        end
                        tccw_pkg::MODE_READ: begin
                            n_state = tccw_pkg::ST_RD_DATA;
                        end
                        tccw_pkg::MODE_CURSOR: begin
                            n_cur_col = (32'(i_col) < COLUMNS) ? CW'(i_col) : MAX_COL;
                            n_cur_row = (32'(i_row) < ROWS) ? RW'(i_row) : LAST_ROW;
                            n_state   = tccw_pkg::ST_FINISH;
                        end
                        tccw_pkg::MODE_CLEAR: begin
                            n_idx   = '0;
                            n_state = tccw_pkg::ST_CLEAR;
                        end
                        default: begin
                            n_state = tccw_pkg::ST_FINISH;
                        end
                    endcase
                end
            end

            tccw_pkg::ST_RD_DATA: begin
                n_res_char = r_rd_ok ? r_rd_char : '0;
                n_res_attr = r_rd_ok ? r_rd_attr : '0;
                n_state    = tccw_pkg::ST_FINISH;
            end

            // scroll first when a wrap is pending on the last row
            tccw_pkg::ST_CHECK: begin
                if ((r_cur_row == LAST_ROW) && (r_cur_col == WRAP_COL)) begin
                    n_idx            = IDX_ROW1;
                    n_cp_valid       = 1'b0;
                    n_scroll_to_body = 1'b1;
                    n_state          = tccw_pkg::ST_SCROLL;
                end else begin
                    n_state = tccw_pkg::ST_BODY;
                end
            end

            tccw_pkg::ST_BODY: begin
                n_state = tccw_pkg::ST_FINISH;
                if (r_ch != tccw_pkg::CH_CR) begin
                    n_cur_col = w_wr_col;
                    n_cur_row = w_wr_row;
                    case (r_ch)
                        tccw_pkg::CH_NUL: begin
                            n_state = tccw_pkg::ST_FINISH;
                        end
                        tccw_pkg::CH_LF: begin
                            if (w_wr_row == LAST_ROW) begin
                                n_idx            = IDX_ROW1;
                                n_cp_valid       = 1'b0;
                                n_scroll_to_body = 1'b0;
                                n_state          = tccw_pkg::ST_SCROLL;
                            end else begin
                                n_cur_row = w_wr_row + 1'b1;
                                n_cur_col = '0;
                            end
                        end
                        tccw_pkg::CH_BS: begin
                            // ignore at the top-left cell
                            if ((w_wr_col != '0) || (w_wr_row != '0)) begin
                                n_cur_col = w_bs_col;
                                n_cur_row = w_bs_row;
                                w_we_char = 1'b1;
                                w_waddr   = w_bs_addr;
                                w_wchar   = tccw_pkg::CH_SPACE;
                            end
                        end
                        tccw_pkg::CH_TAB: begin
                            n_ch      = tccw_pkg::CH_SPACE;
                            n_tab_cnt = 2'd3;
                            n_state   = tccw_pkg::ST_CHECK;
                        end
                        default: begin
                            w_we_char = 1'b1;
                            w_waddr   = w_put_addr;
                            w_wchar   = r_ch;
                            n_cur_col = w_wr_col + 1'b1;
                            if (r_tab_cnt != '0) begin
                                n_tab_cnt = r_tab_cnt - 1'b1;
                                n_state   = tccw_pkg::ST_CHECK;
                            end
                        end
                    endcase
                end
            end

            // read row r+1 ahead, write it one row up in the next cycle
            tccw_pkg::ST_SCROLL: begin
                if (r_cp_valid) begin
                    w_we_char = 1'b1;
                    w_we_attr = 1'b1;
                    w_waddr   = r_cp_addr;
                    w_wchar   = r_rd_char;
                    w_wattr   = r_rd_attr;
                end
                w_raddr    = r_idx;
                n_cp_valid = 1'b1;
                n_cp_addr  = r_idx - IDX_ROW1;
                if (r_idx == IDX_LAST) begin
                    n_idx   = IDX_LAST_ROW;
                    n_state = tccw_pkg::ST_FILL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            tccw_pkg::ST_FILL: begin
                w_we_char = 1'b1;
                w_we_attr = 1'b1;
                if (r_cp_valid) begin
                    // drain the last copy before blanking the freed row
                    w_waddr    = r_cp_addr;
                    w_wchar    = r_rd_char;
                    w_wattr    = r_rd_attr;
                    n_cp_valid = 1'b0;
                end else if (r_idx == IDX_LAST) begin
                    n_cur_col = '0;
                    n_scrolls = r_scrolls + 32'd1;
                    n_state   = r_scroll_to_body ? tccw_pkg::ST_BODY : tccw_pkg::ST_FINISH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            tccw_pkg::ST_CLEAR: begin
                w_we_char = 1'b1;
                w_we_attr = 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_cur_col = '0;
                    n_cur_row = '0;
                    n_state   = tccw_pkg::ST_FINISH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            tccw_pkg::ST_FINISH: begin
                // hold until the output register is free or being emptied
                if (!r_out_valid || !i_stall) begin
                    n_out_valid   = 1'b1;
                    n_out_col     = tccw_pkg::OUT_COL_W'(r_cur_col);
                    n_out_row     = tccw_pkg::OUT_ROW_W'(r_cur_row);
                    n_out_lin     = tccw_pkg::OUT_LIN_W'(w_lin);
                    n_out_char    = r_res_char;
                    n_out_attr    = r_res_attr;
                    n_out_scrolls = r_scrolls;
                    n_state       = tccw_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = tccw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we_char) begin
            r_char_mem[w_waddr] <= w_wchar;
        end
        if (w_we_attr) begin
            r_attr_mem[w_waddr] <= w_wattr;
        end
        r_rd_char <= r_char_mem[w_raddr];
        r_rd_attr <= r_attr_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tccw_pkg::ST_INIT;
            r_idx       <= '0;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_scrolls   <= '0;
            r_cp_valid  <= 1'b0;
            r_tab_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_fill_attr <= tccw_pkg::RESET_FILL_ATTR;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_scrolls   <= n_scrolls;
            r_cp_valid  <= n_cp_valid;
            r_tab_cnt   <= n_tab_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_fill_attr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch             <= n_ch;
        r_cp_addr        <= n_cp_addr;
        r_scroll_to_body <= n_scroll_to_body;
        r_rd_ok          <= n_rd_ok;
        r_res_char       <= n_res_char;
        r_res_attr       <= n_res_attr;
        r_out_col        <= n_out_col;
        r_out_row        <= n_out_row;
        r_out_lin        <= n_out_lin;
        r_out_char       <= n_out_char;
        r_out_attr       <= n_out_attr;
        r_out_scrolls    <= n_out_scrolls;
    end

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_col <= WRAP_COL) && (r_cur_row <= LAST_ROW))
        else $error("cursor left the screen");

    a_copy_in_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_valid |-> (r_state == tccw_pkg::ST_SCROLL || r_state == tccw_pkg::ST_FILL))
        else $error("scroll copy pending outside a scroll");

    a_scroll_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tccw_pkg::ST_FILL && !r_cp_valid && r_idx == IDX_LAST)
        |=> (r_scrolls == $past(r_scrolls) + 32'd1) && (r_cur_col == '0))
        else $error("scroll end did not count or home the column");

    a_tab_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tab_cnt != '0) |-> (r_ch == tccw_pkg::CH_SPACE))
        else $error("tab expansion with a character other than space");

endmodule

>>> test/console_result_checker.sv
`timescale 1ns / 1ps

module console_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel as seen at the block
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_char_code,
    input  logic [6:0]  i_col,
    input  logic [4:0]  i_row,
    // result channel as seen at the block
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [6:0]  i_cursor_col,
    input  logic [4:0]  i_cursor_row,
    input  logic [10:0] i_cursor_linear,
    input  logic [7:0]  i_cell_char,
    input  logic [7:0]  i_cell_attr,
    input  logic [31:0] i_scroll_count,
    // configuration channel
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int COLS        = 80;
    localparam int LINES       = 25;
    localparam int CELLS       = COLS * LINES;

    typedef struct packed {
        logic [tccw_pkg::OUT_COL_W-1:0] cursor_col;
        logic [tccw_pkg::OUT_ROW_W-1:0] cursor_row;
        logic [tccw_pkg::OUT_LIN_W-1:0] cursor_linear;
        logic [7:0]                     cell_char;
        logic [7:0]                     cell_attr;
        logic [31:0]                    scroll_count;
    } t_console_result;

    logic [7:0]      screen_char [CELLS];
    logic [7:0]      screen_attr [CELLS];
    logic [6:0]      cur_col;
    logic [4:0]      cur_line;
    logic [31:0]     scroll_total;
    logic [7:0]      fill_attr;
    t_console_result results_due [$];
    int              mismatch_total = 0;
    int              results_seen = 0;

    task automatic log_failure(input string msg);
        mismatch_total++;
        $display("%0t: %s", $time, msg);
    endtask

    function automatic void blank_screen();
        int i;
        for (i = 0; i < CELLS; i++) begin
            screen_char[i] = tccw_pkg::CH_SPACE;
            screen_attr[i] = fill_attr;
        end
        cur_col  = '0;
        cur_line = '0;
    endfunction

    function automatic void scroll_up();
        int i;
        for (i = 0; i < CELLS - COLS; i++) begin
            screen_char[i] = screen_char[i + COLS];
            screen_attr[i] = screen_attr[i + COLS];
        end
        for (i = CELLS - COLS; i < CELLS; i++) begin
            screen_char[i] = tccw_pkg::CH_SPACE;
            screen_attr[i] = fill_attr;
        end
        cur_col = '0;
        scroll_total++;
    endfunction

    // Overwrite the character at the cursor, keep the attribute.
    function automatic void write_char(input logic [7:0] c);
        int idx;
        idx = int'(cur_line) * COLS + int'(cur_col);
        if (idx < CELLS) begin
            screen_char[idx] = c;
        end
    endfunction

    function automatic void put_byte(input logic [7:0] c);
        // scroll first when a wrap is pending on the last line
        if (int'(cur_line) == LINES - 1 && int'(cur_col) >= COLS) begin
            scroll_up();
        end
        if (c == tccw_pkg::CH_CR) begin
            return;
        end
        if (int'(cur_col) >= COLS) begin
            if (int'(cur_line) < LINES - 1) begin
                cur_line++;
            end
            cur_col = '0;
        end
        case (c)
            tccw_pkg::CH_NUL, tccw_pkg::CH_TAB: begin
                // tab spaces are put by the caller
            end
            tccw_pkg::CH_LF: begin
                if (int'(cur_line) >= LINES - 1) begin
                    scroll_up();
                end else begin
                    cur_line++;
                    cur_col = '0;
                end
            end
            tccw_pkg::CH_BS: begin
                if (cur_col == '0) begin
                    if (cur_line == '0) begin
                        return;
                    end
                    cur_line--;
                    cur_col = 7'(COLS - 1);
                end else begin
                    cur_col--;
                end
                write_char(tccw_pkg::CH_SPACE);
            end
            default: begin
                write_char(c);
                cur_col++;
            end
        endcase
    endfunction

    function automatic t_console_result predict_step(input tccw_pkg::t_mode m,
                                                     input logic [7:0] c,
                                                     input logic [6:0] x,
                                                     input logic [4:0] y);
        t_console_result r;
        int idx;
        r = '0;
        case (m)
            tccw_pkg::MODE_PUT: begin
                put_byte(c);
                if (c == tccw_pkg::CH_TAB) begin
                    repeat (4) put_byte(tccw_pkg::CH_SPACE);
                end
            end
            tccw_pkg::MODE_READ: begin
                if (int'(x) < COLS && int'(y) < LINES) begin
                    idx = int'(y) * COLS + int'(x);
                    r.cell_char = screen_char[idx];
                    r.cell_attr = screen_attr[idx];
                end
            end
            tccw_pkg::MODE_CURSOR: begin
                cur_col  = (int'(x) < COLS) ? x : 7'(COLS - 1);
                cur_line = (int'(y) < LINES) ? y : 5'(LINES - 1);
            end
            default: begin
                blank_screen();
            end
        endcase
        r.cursor_col    = cur_col;
        r.cursor_row    = cur_line;
        r.cursor_linear = 11'(int'(cur_line) * COLS + int'(cur_col));
        r.scroll_count  = scroll_total;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            log_failure($sformatf("result %0d %s: got %0d, expected %0d",
                                  results_seen, name, got, want));
        end
    endtask

    task automatic check_result();
        t_console_result want;
        results_seen++;
        if (results_due.size() == 0) begin
            log_failure($sformatf("result %0d arrived with nothing expected", results_seen));
            return;
        end
        want = results_due.pop_front();
        compare_field("cursor_col", 32'(i_cursor_col), 32'(want.cursor_col));
        compare_field("cursor_row", 32'(i_cursor_row), 32'(want.cursor_row));
        compare_field("cursor_linear", 32'(i_cursor_linear), 32'(want.cursor_linear));
        compare_field("cell_char", 32'(i_cell_char), 32'(want.cell_char));
        compare_field("cell_attr", 32'(i_cell_attr), 32'(want.cell_attr));
        compare_field("scroll_count", i_scroll_count, want.scroll_count);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_attr = tccw_pkg::RESET_FILL_ATTR;
            blank_screen();
            scroll_total = '0;
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                fill_attr = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                results_due.push_back(predict_step(tccw_pkg::t_mode'(i_mode),
                                                   i_char_code, i_col, i_row));
            end
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
        end
        o_pending    <= results_due.size();
        o_fail_count <= mismatch_total;
    end

endmodule

>>> test/text_console_cell_writer_unit_tb.sv
`timescale 1ns / 1ps

module text_console_cell_writer_unit_tb;

    localparam int WORDS_WANTED = 1675;
    localparam int PHASE_WORDS  = 210;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [1:0]  in_mode = '0;
    logic [7:0]  in_char = '0;
    logic [6:0]  in_col = '0;
    logic [4:0]  in_row = '0;
    logic        rx_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data = '0;

    logic        in_stall;
    logic        out_valid;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_linear;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [31:0] scroll_count;
    logic        cfg_ready;

    int fail_count;
    int pending;
    int words_sent = 0;
    int idle_cycles = 0;
    bit long_hold_req = 1'b0;
    bit tx_gapless = 1'b0;
    bit tx_driving = 1'b0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    text_console_cell_writer_unit i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_mode         (in_mode),
        .i_char_code    (in_char),
        .i_col          (in_col),
        .i_row          (in_row),
        .o_valid        (out_valid),
        .i_stall        (rx_stall),
        .o_cursor_col   (cursor_col),
        .o_cursor_row   (cursor_row),
        .o_cursor_linear(cursor_linear),
        .o_cell_char    (cell_char),
        .o_cell_attr    (cell_attr),
        .o_scroll_count (scroll_count),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    console_result_checker u_console_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_mode         (in_mode),
        .i_char_code    (in_char),
        .i_col          (in_col),
        .i_row          (in_row),
        .i_out_valid    (out_valid),
        .i_out_stall    (rx_stall),
        .i_cursor_col   (cursor_col),
        .i_cursor_row   (cursor_row),
        .i_cursor_linear(cursor_linear),
        .i_cell_char    (cell_char),
        .i_cell_attr    (cell_attr),
        .i_scroll_count (scroll_count),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [6:0] rnd_col();
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [4:0] rnd_row();
        return 5'($urandom_range(0, 31));
    endfunction

    // Mostly printable text with a sprinkling of control codes.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 8'($urandom_range(32, 126));
        if (r < 68) return tccw_pkg::CH_LF;
        if (r < 76) return tccw_pkg::CH_BS;
        if (r < 81) return tccw_pkg::CH_TAB;
        if (r < 85) return tccw_pkg::CH_CR;
        if (r < 88) return tccw_pkg::CH_NUL;
        return rnd_byte();
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_gapless) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic int pick_run();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 8);
        if (r < 92) return $urandom_range(9, 40);
        return $urandom_range(60, 200);
    endfunction

    task automatic drop_valid();
        if (tx_driving) begin
            in_valid   <= 1'b0;
            tx_driving = 1'b0;
        end
    endtask

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input tccw_pkg::t_mode m, input logic [7:0] c,
                             input logic [6:0] x, input logic [4:0] y);
        int gap;
        in_valid   <= 1'b1;
        tx_driving = 1'b1;
        in_mode    <= m;
        in_char    <= c;
        in_col     <= x;
        in_row     <= y;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            drop_valid();
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        drop_valid();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_fill(input logic [7:0] attr);
        wait_drained();
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= attr;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_burst();
        int kind;
        int n;
        int r;
        logic [6:0] x;
        logic [4:0] y;
        kind = $urandom_range(0, 99);
        tx_gapless = ($urandom_range(0, 4) == 0);
        if (kind < 55) begin
            // place the cursor, often near a line end or on the last line, then type
            r = $urandom_range(0, 9);
            if (r < 4) begin
                send_word(tccw_pkg::MODE_CURSOR, rnd_byte(), 7'($urandom_range(0, 79)),
                          5'($urandom_range(0, 24)));
            end else if (r < 7) begin
                send_word(tccw_pkg::MODE_CURSOR, rnd_byte(), 7'($urandom_range(70, 79)),
                          5'($urandom_range(0, 24)));
            end else if (r < 9) begin
                send_word(tccw_pkg::MODE_CURSOR, rnd_byte(), 7'($urandom_range(60, 79)),
                          5'd24);
            end
            n = $urandom_range(3, 14);
            repeat (n) send_word(tccw_pkg::MODE_PUT, pick_char(), rnd_col(), rnd_row());
        end else if (kind < 70) begin
            n = $urandom_range(2, 6);
            repeat (n) begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    x = rnd_col();
                    y = rnd_row();
                end else if (r < 4) begin
                    x = 7'($urandom_range(0, 79));
                    y = 5'($urandom_range(23, 24));
                end else begin
                    x = 7'($urandom_range(0, 79));
                    y = 5'($urandom_range(0, 24));
                end
                send_word(tccw_pkg::MODE_READ, rnd_byte(), x, y);
            end
        end else if (kind < 85) begin
            n = $urandom_range(1, 3);
            repeat (n) send_word(tccw_pkg::MODE_CURSOR, rnd_byte(), rnd_col(), rnd_row());
        end else if (kind < 88) begin
            send_word(tccw_pkg::MODE_CLEAR, rnd_byte(), rnd_col(), rnd_row());
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                send_word(tccw_pkg::t_mode'($urandom_range(0, 3)), rnd_byte(),
                          rnd_col(), rnd_row());
            end
        end
        tx_gapless = 1'b0;
    endtask

    // Result side: random stalls, quiet runs, and one long hold on request.
    initial begin : result_sink
        int hold;
        int run;
        int i;
        @(posedge clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else begin
                hold = pick_stall();
            end
            if (hold > 0) begin
                rx_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rx_stall <= 1'b0;
            run = pick_run();
            i = 0;
            do begin
                @(posedge clk);
                i++;
            end while (i < run && !long_hold_req);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !rx_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("text_console_cell_writer_unit regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int phase;
        int phase_end;
        logic [7:0] attr;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed words, fill attribute still at its reset value
        send_word(tccw_pkg::MODE_READ, 8'h00, 7'd0, 5'd0);
        send_word(tccw_pkg::MODE_READ, 8'hff, 7'd127, 5'd31);
        send_word(tccw_pkg::MODE_READ, 8'h00, 7'd80, 5'd24);
        send_word(tccw_pkg::MODE_READ, 8'h00, 7'd79, 5'd25);
        send_word(tccw_pkg::MODE_PUT, 8'h41, 7'd127, 5'd31);
        send_word(tccw_pkg::MODE_PUT, 8'hff, 7'd0, 5'd0);
        send_word(tccw_pkg::MODE_PUT, tccw_pkg::CH_CR, 7'd0, 5'd0);
        send_word(tccw_pkg::MODE_PUT, tccw_pkg::CH_NUL, 7'd0, 5'd0);
        send_word(tccw_pkg::MODE_PUT, tccw_pkg::CH_TAB, 7'd0, 5'd0);
        send_word(tccw_pkg::MODE_PUT, tccw_pkg::CH_BS, 7'd0, 5'd0);
        send_word(tccw_pkg::MODE_PUT, tccw_pkg::CH_LF, 7'd0, 5'd0);
        send_word(tccw_pkg::MODE_READ, 8'h00, 7'd0, 5'd0);
        // pending wrap, then a NUL that only takes the wrap
        send_word(tccw_pkg::MODE_CURSOR, 8'h00, 7'd79, 5'd0);
        send_word(tccw_pkg::MODE_PUT, 8'h42, 7'd0, 5'd0);
        send_word(tccw_pkg::MODE_PUT, tccw_pkg::CH_NUL, 7'd0, 5'd0);
        // backspace at the top-left cell, then across a line boundary
        send_word(tccw_pkg::MODE_CURSOR, 8'h00, 7'd0, 5'd0);
        send_word(tccw_pkg::MODE_PUT, tccw_pkg::CH_BS, 7'd0, 5'd0);
        send_word(tccw_pkg::MODE_CURSOR, 8'h00, 7'd0, 5'd1);
        send_word(tccw_pkg::MODE_PUT, tccw_pkg::CH_BS, 7'd0, 5'd0);
        // saturated cursor, pending wrap on the last line, scroll ahead of CR
        send_word(tccw_pkg::MODE_CURSOR, 8'h00, 7'd127, 5'd31);
        send_word(tccw_pkg::MODE_PUT, 8'h43, 7'd0, 5'd0);
        send_word(tccw_pkg::MODE_PUT, tccw_pkg::CH_CR, 7'd0, 5'd0);
        // scroll ahead of a newline that scrolls again
        send_word(tccw_pkg::MODE_CURSOR, 8'h00, 7'd79, 5'd24);
        send_word(tccw_pkg::MODE_PUT, 8'h44, 7'd0, 5'd0);
        send_word(tccw_pkg::MODE_PUT, tccw_pkg::CH_LF, 7'd0, 5'd0);
        // tab that runs off the last line part way through
        send_word(tccw_pkg::MODE_CURSOR, 8'h00, 7'd77, 5'd24);
        send_word(tccw_pkg::MODE_PUT, tccw_pkg::CH_TAB, 7'd0, 5'd0);
        send_word(tccw_pkg::MODE_READ, 8'h00, 7'd79, 5'd23);
        send_word(tccw_pkg::MODE_CLEAR, 8'hff, 7'd127, 5'd31);

        phase = 0;
        while (words_sent < WORDS_WANTED) begin
            case (phase)
                0:       attr = 8'h00;
                1:       attr = 8'hff;
                default: attr = rnd_byte();
            endcase
            write_fill(attr);
            if (phase == 1) begin
                // hold results off for a long stretch and keep offering words
                long_hold_req = 1'b1;
                while (long_hold_req) @(posedge clk);
                tx_gapless = 1'b1;
                repeat (30) send_word(tccw_pkg::MODE_PUT, pick_char(), rnd_col(), rnd_row());
                tx_gapless = 1'b0;
            end
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end && words_sent < WORDS_WANTED) begin
                run_burst();
            end
            phase++;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("text_console_cell_writer_unit regression: pass");
        end else begin
            $display("text_console_cell_writer_unit regression: fail");
        end
        $finish;
    end

endmodule
